>>> rtl/sha256_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions for the stream hasher.
// ---------------------------------------------------------------------------
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Front-to-back work queue entry: one full 512-bit block.
    typedef struct packed {
        logic [511:0] block;
        logic         final_blk;
    } blk_item_t;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam int         LENGTH_POS = 56;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_ADD,
        BK_EMIT
    } bk_state_t;

    typedef enum logic [1:0] {
        FR_TAKE,
        FR_PAD2
    } fr_state_t;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> rtl/sha256_front.sv
// ---------------------------------------------------------------------------
// SHA-256 front end
// Collects bytes into 512-bit blocks, pads at message end, pushes blocks.
// ---------------------------------------------------------------------------
module sha256_front
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      push,
    output blk_item_t push_data,
    input  logic      q_full
);

    logic [511:0] buf_reg, buf_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  total_reg, total_next;
    fr_state_t    state_reg, state_next;
    // Whether the second padding block still needs the pad byte.
    logic         pad_first_reg, pad_first_next;
    logic [511:0] b1, b2;
    logic [63:0]  bits;
    logic [6:0]   f1;
    logic [5:0]   pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            total_reg <= '0;
            state_reg <= FR_TAKE;
        end
        else
        begin
            fill_reg  <= fill_next;
            total_reg <= total_next;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    // Byte i of a block sits at bits [511-8i -: 8].
    always_comb
    begin
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        state_next = state_reg;
        push       = 1'b0;
        push_data  = '0;
        in_stall   = q_full || (state_reg == FR_PAD2);
        b1         = buf_reg;
        f1         = {1'b0, fill_reg};
        b2         = '0;
        pos        = '0;
        bits       = '0;
        case (state_reg)
            FR_TAKE:
            begin
                if (in_valid && !q_full)
                begin
                    total_next = total_reg;
                    if (in_data.byte_present)
                    begin
                        b1[511 - 8*fill_reg -: 8] = in_data.data_byte;
                        f1 = {1'b0, fill_reg} + 7'd1;
                        total_next = total_reg + 61'd1;
                    end
                    bits = {total_next, 3'b000};
                    if (f1[6])
                    begin
                        push           = 1'b1;
                        push_data      = '{block: b1, final_blk: 1'b0};
                        fill_next      = '0;
                        buf_next       = b1;
                        if (in_data.end_of_message)
                            state_next = FR_PAD2;
                    end
                    else if (in_data.end_of_message)
                    begin
                        pos = f1[5:0];
                        for (int i = 0; i < 64; i++)
                        begin
                            if (i < pos)
                                b2[511 - 8*i -: 8] = b1[511 - 8*i -: 8];
                            else if (i == pos)
                                b2[511 - 8*i -: 8] = PAD_BYTE;
                        end
                        push = 1'b1;
                        if (pos < 6'(LENGTH_POS))
                        begin
                            b2[63:0]   = bits;
                            push_data  = '{block: b2, final_blk: 1'b1};
                            fill_next  = '0;
                            total_next = '0;
                        end
                        else
                        begin
                            // No room for the length; it goes in an extra block.
                            push_data  = '{block: b2, final_blk: 1'b0};
                            buf_next   = '0;
                            fill_next  = '0;
                            state_next = FR_PAD2;
                        end
                    end
                    else
                    begin
                        buf_next  = b1;
                        fill_next = f1[5:0];
                    end
                end
            end
            FR_PAD2:
            begin
                // Either a full block just closed (pad starts a new one) or
                // the pad byte already went out (zeros plus length).
                bits = {total_reg, 3'b000};
                b2   = '0;
                if (!q_full)
                begin
                    b2[511 -: 8] = pad_first_reg ? PAD_BYTE : 8'h00;
                    b2[63:0]     = bits;
                    push         = 1'b1;
                    push_data    = '{block: b2, final_blk: 1'b1};
                    total_next   = '0;
                    fill_next    = '0;
                    state_next   = FR_TAKE;
                end
            end
            default: state_next = FR_TAKE;
        endcase
    end

    always_comb
    begin
        pad_first_next = pad_first_reg;
        if (state_reg == FR_TAKE && in_valid && !q_full && in_data.end_of_message)
            pad_first_next = f1[6];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_first_reg <= 1'b0;
        else
            pad_first_reg <= pad_first_next;
    end

endmodule

>>> rtl/sha256_queue.sv
// ---------------------------------------------------------------------------
// SHA-256 block queue
// Two-entry FIFO of blocks between the front end and the compressor.
// ---------------------------------------------------------------------------
module sha256_queue
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  blk_item_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output blk_item_t head
);

    blk_item_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

endmodule

>>> rtl/sha256_back.sv
// ---------------------------------------------------------------------------
// SHA-256 compressor
// One round per cycle, rolling 16-word schedule, digest word emitter.
// ---------------------------------------------------------------------------
module sha256_back
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_not_empty,
    input  blk_item_t q_head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    bk_state_t    state_reg, state_next;
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  w_reg [16];
    logic [5:0]   t_reg;
    logic [2:0]   idx_reg;
    logic         fin_reg;
    logic [31:0]  s0, s1, ch, mj, t1, t2, wn, wt;

    always_comb
    begin
        wt = w_reg[0];
        s1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + ROUND_K[t_reg] + wt;
        s0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = s0 + mj;
        wn = (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10))
           + w_reg[9]
           + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
           + w_reg[0];
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        out_valid  = state_reg == BK_EMIT;
        out_data   = '{digest_word: h_reg[idx_reg], word_index: idx_reg,
                       last_word: idx_reg == 3'd7};
        case (state_reg)
            BK_IDLE:
                if (q_not_empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_ROUND;
                end
            BK_ROUND:
                if (t_reg == 6'd63)
                    state_next = BK_ADD;
            BK_ADD:
                state_next = fin_reg ? BK_EMIT : BK_IDLE;
            BK_EMIT:
                if (!out_stall && idx_reg == 3'd7)
                    state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            t_reg     <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= INIT_H[i];
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                BK_IDLE:
                begin
                    t_reg <= '0;
                    if (pop)
                        fin_reg <= q_head.final_blk;
                end
                BK_ROUND: t_reg <= t_reg + 6'd1;
                BK_ADD:
                begin
                    idx_reg <= '0;
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                end
                BK_EMIT:
                    if (!out_stall)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= INIT_H[i];
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE && pop)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= q_head.block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (state_reg == BK_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wn;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

>>> rtl/sha256_stream_hasher.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with a decoupled block assembler and round engine.
// ---------------------------------------------------------------------------
// Usage:
//   in channel: one transaction per cycle carries an optional byte
//   (byte_present) and an optional end-of-message mark. Bytes gather in
//   the front end; each full 64-byte block goes to a two-block queue.
//   out channel: after end-of-message, eight digest transactions, word 0
//   (most significant) first, last_word set on word 7.
//   Throughput: a byte per cycle while the queue has room; the round engine
//   does one SHA-256 round per cycle, so a long stream averages about one
//   byte per cycle and stalls when the queue fills.
//   From end-of-message to word 0 the final block passes the queue, the
//   rounds and the chaining add; an extra length block adds one more pass.
//   Reset: chaining words to the initial hash, buffer empty, queue empty.
//   Out stall holds the current word; the round engine waits, the queue
//   fills, and then in_stall rises.
// ---------------------------------------------------------------------------
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic      push, q_full, pop, q_ne;
    blk_item_t push_data, head;

    sha256_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_data,
        .push, .push_data, .q_full
    );

    sha256_queue u_queue (
        .clk, .rst_n, .push, .push_data, .full(q_full),
        .pop, .not_empty(q_ne), .head
    );

    sha256_back u_back (
        .clk, .rst_n, .q_not_empty(q_ne), .q_head(head), .pop,
        .out_valid, .out_stall, .out_data
    );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives byte streams with random idle and stall bursts, predicts digests
// with an independent SHA-256 model, and checks every digest word in order.
// ---------------------------------------------------------------------------

// Digest predictor and in-order checker for the stream hasher.
class digest_board;
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [60:0] total;
    sha256_pkg::out_item_t pending [$];
    int errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::INIT_H[i];
        fill  = 0;
        total = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void crunch();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + sha256_pkg::ROUND_K[t] + w[t];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // Note one accepted input transaction.
    function void note_input(sha256_pkg::in_item_t it);
        logic [63:0] bits;
        sha256_pkg::out_item_t o;
        if (it.byte_present)
        begin
            blk[fill] = it.data_byte;
            fill++;
            total++;
            if (fill == 64)
            begin
                crunch();
                fill = 0;
            end
        end
        if (!it.end_of_message) return;
        blk[fill] = sha256_pkg::PAD_BYTE;
        fill++;
        if (fill > sha256_pkg::LENGTH_POS)
        begin
            for (int i = fill; i < 64; i++) blk[i] = 8'h00;
            crunch();
            fill = 0;
        end
        for (int i = fill; i < sha256_pkg::LENGTH_POS; i++) blk[i] = 8'h00;
        bits = {total, 3'b000};
        for (int i = 0; i < 8; i++) blk[sha256_pkg::LENGTH_POS + i] = bits[63 - 8*i -: 8];
        crunch();
        for (int i = 0; i < 8; i++)
        begin
            o.digest_word = chain[i];
            o.word_index  = i[2:0];
            o.last_word   = (i == 7);
            pending.push_back(o);
        end
        restart();
    endfunction

    // Check one accepted output transaction against the oldest expectation.
    function void check_output(sha256_pkg::out_item_t got);
        sha256_pkg::out_item_t exp;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                     got.digest_word, got.word_index, got.last_word);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.digest_word !== exp.digest_word)
        begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     exp.digest_word, got.digest_word);
            errors++;
        end
        if (got.word_index !== exp.word_index)
        begin
            $display("%0t: word_index expected %0d actual %0d", $time,
                     exp.word_index, got.word_index);
            errors++;
        end
        if (got.last_word !== exp.last_word)
        begin
            $display("%0t: last_word expected %0b actual %0b", $time,
                     exp.last_word, got.last_word);
            errors++;
        end
    endfunction
endclass

module tb;
    import sha256_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    digest_board board;
    bit quiet;          // no idling/stall bursts in the closing stretch
    int sent;

    sha256_stream_hasher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Monitor: sample both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall) board.note_input(in_data);
        if (rst_n && out_valid && !out_stall) board.check_output(out_data);
    end

    // Receiver: random stall bursts, none in the closing stretch.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 14);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Send one transaction; optionally idle for a burst beforehand.
    // Called at a falling edge; returns at the falling edge after acceptance.
    // Valid stays high on return; the next call or the caller drops it.
    task automatic send(input logic [7:0] b, input logic pres, input logic eom);
        int n;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, byte_present: pres, end_of_message: eom};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        sent++;
    endtask

    // A message of len random bytes; ends with a byte+end item or a bare end.
    task automatic message(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            // occasional ignored filler with random data
            if ($urandom_range(0, 15) == 0)
                send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send(b, 1'b1, (i == len - 1) && $urandom_range(0, 1));
            if (i == len - 1 && in_data.end_of_message) return;
        end
        send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        int len;
        board     = new();
        quiet     = 1'b0;
        sent      = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty message, ignored byte, byte with end, extremes.
        send(8'hff, 1'b0, 1'b1);
        send(8'h00, 1'b1, 1'b1);
        send(8'hff, 1'b1, 1'b0);
        send(8'h5a, 1'b0, 1'b0);
        send(8'h00, 1'b1, 1'b0);
        send(8'haa, 1'b1, 1'b1);
        send(8'h55, 1'b0, 1'b1);
        send(8'hff, 1'b1, 1'b0);
        send(8'hff, 1'b1, 1'b0);
        send(8'h00, 1'b0, 1'b1);

        // Random messages; lengths around the 55/56 and 64-byte boundaries.
        while (sent < 150)
        begin
            case ($urandom_range(0, 5))
                0: len = 0;
                1: len = $urandom_range(54, 57);
                2: len = $urandom_range(63, 65);
                3: len = $urandom_range(100, 130);
                default: len = $urandom_range(1, 12);
            endcase
            if (sent + len > 152) len = 152 - sent;
            if (sent > 120) quiet = 1'b1;
            message(len);
        end
        quiet = 1'b1;
        message(56);
        in_valid <= 1'b0;

        while (board.pending.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
